// File: rtl/core/pirm_pkg.sv
// Shared types and constants for the positional insert / range minimum core.
// Used by pirm_front, pirm_back and positional_insert_range_min_core.
`default_nettype none

package pirm_pkg;

	localparam int POS_W = 11;
	localparam int VAL_W = 32;

	localparam logic signed [VAL_W-1:0] EMPTY_SENTINEL = 32'sd1000000001;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_QUERY  = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t                     cmd;
		logic [POS_W-1:0]         pos;
		logic signed [VAL_W-1:0]  value;
		logic [POS_W-1:0]         lo;
		logic [POS_W-1:0]         hi;
	} req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0]  range_min;
		logic                     range_empty;
		logic                     insert_dropped;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_DRAIN,
		ST_PUT,
		ST_SCAN,
		ST_FOLD
	} back_state_t;

endpackage

`default_nettype wire

// File: rtl/core/pirm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pirm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/core/pirm_front.sv
// Front end: takes requests, normalizes the left bound and queues them
// in a two-entry FIFO for the back end. Depends on pirm_pkg.
`default_nettype none

module pirm_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic                          command,
	input  wire logic [pirm_pkg::POS_W-1:0]    insert_position,
	input  wire logic signed [pirm_pkg::VAL_W-1:0] insert_value,
	input  wire logic [pirm_pkg::POS_W-1:0]    query_left,
	input  wire logic [pirm_pkg::POS_W-1:0]    query_right,
	output logic                               busy,
	output pirm_pkg::req_t                     req,
	output logic                               req_valid,
	input  wire logic                          req_pop
);

	import pirm_pkg::*;

	req_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;
	req_t       req_in;

	assign busy      = (fill_q == 2'd2);
	assign push      = start && !busy;
	assign req_valid = (fill_q != 2'd0);
	assign req       = slot_q[rd_ptr_q];

	// left bound zero means position one
	always_comb begin
		req_in.cmd   = cmd_t'(command);
		req_in.pos   = insert_position;
		req_in.value = insert_value;
		req_in.lo    = (query_left == '0) ? POS_W'(1) : query_left;
		req_in.hi    = query_right;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= req_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (req_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, req_pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/pirm_back.sv
// Back end: executes queued requests against the element RAM, shifting
// one entry per cycle on insert and scanning one per cycle on query.
// Depends on pirm_pkg and pirm_ram.
`default_nettype none

module pirm_back #(
	parameter int MAX_ELEMENTS = 1024
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire pirm_pkg::req_t                    req,
	input  wire logic                              req_valid,
	output logic                                   req_pop,
	output logic                                   done,
	output pirm_pkg::result_t                      result,
	output logic [$clog2(MAX_ELEMENTS+1)-1:0]      count
);

	import pirm_pkg::*;

	localparam int CW = $clog2(MAX_ELEMENTS + 1);
	localparam int AW = $clog2(MAX_ELEMENTS);
	localparam int PW = (CW > POS_W) ? CW : POS_W;

	back_state_t state_q, state_d;

	logic [CW-1:0]          count_q;
	logic [AW-1:0]          a_q;
	logic [AW-1:0]          pos_q;
	logic [AW-1:0]          end_q;
	logic signed [VAL_W-1:0] val_q;
	logic                   pend_q;
	logic [AW-1:0]          pend_addr_q;
	logic                   rv_q;
	logic                   have_q;
	logic signed [VAL_W-1:0] acc_q;
	logic                   done_q;
	result_t                result_q;

	logic [PW-1:0]          cnt_ext;
	logic [PW-1:0]          pos_ext;
	logic [PW-1:0]          lo_ext;
	logic [PW-1:0]          hi_ext;
	logic [PW-1:0]          pos_c;
	logic [PW-1:0]          hi_c;
	logic                   full;
	logic                   q_empty;

	logic                   emit;
	result_t                res_d;
	logic signed [VAL_W-1:0] rd_val;
	logic                   we;
	logic [AW-1:0]          waddr;
	logic [VAL_W-1:0]       wdata;
	logic [VAL_W-1:0]       rdata;

	pirm_ram #(
		.WIDTH(VAL_W),
		.DEPTH(MAX_ELEMENTS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (a_q),
		.rdata (rdata)
	);

	assign rd_val  = $signed(rdata);
	assign cnt_ext = PW'(count_q);
	assign pos_ext = PW'(req.pos);
	assign lo_ext  = PW'(req.lo);
	assign hi_ext  = PW'(req.hi);
	assign pos_c   = (pos_ext > cnt_ext) ? cnt_ext : pos_ext;
	assign hi_c    = (hi_ext > cnt_ext) ? cnt_ext : hi_ext;
	assign full    = (count_q == CW'(MAX_ELEMENTS));
	assign q_empty = (lo_ext > hi_c);

	// a pending shift write takes the port; the new value goes in afterwards
	assign we    = pend_q || (state_q == ST_PUT);
	assign waddr = pend_q ? pend_addr_q : pos_q;
	assign wdata = pend_q ? rdata : val_q;

	always_comb begin
		state_d = state_q;
		req_pop = 1'b0;
		emit    = 1'b0;
		res_d   = '{range_min: '0, range_empty: 1'b0, insert_dropped: 1'b0};
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					req_pop = 1'b1;
					if (req.cmd == CMD_INSERT) begin
						if (full) begin
							emit                 = 1'b1;
							res_d.insert_dropped = 1'b1;
						end else if (pos_c == cnt_ext) begin
							state_d = ST_PUT;
						end else begin
							state_d = ST_SHIFT;
						end
					end else begin
						if (q_empty) begin
							emit              = 1'b1;
							res_d.range_min   = EMPTY_SENTINEL;
							res_d.range_empty = 1'b1;
						end else begin
							state_d = ST_SCAN;
						end
					end
				end
			end
			ST_SHIFT: begin
				if (a_q == pos_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_PUT;
			end
			ST_PUT: begin
				emit    = 1'b1;
				state_d = ST_IDLE;
			end
			ST_SCAN: begin
				if (a_q == end_q) begin
					state_d = ST_FOLD;
				end
			end
			ST_FOLD: begin
				emit            = 1'b1;
				res_d.range_min = (have_q && acc_q < rd_val) ? acc_q : rd_val;
				state_d         = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			pend_q  <= 1'b0;
			rv_q    <= 1'b0;
			have_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= emit;
			pend_q  <= (state_q == ST_SHIFT);
			rv_q    <= (state_q == ST_SCAN);
			if (req_pop) begin
				have_q <= 1'b0;
			end else if (state_q == ST_SCAN && rv_q) begin
				have_q <= 1'b1;
			end
			if (state_q == ST_PUT) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_q <= res_d;
		end
		case (state_q)
			ST_IDLE: begin
				if (req_pop) begin
					// shift walks down from the last element, scan walks up from left
					a_q   <= (req.cmd == CMD_INSERT) ? AW'(cnt_ext - PW'(1))
					                                 : AW'(lo_ext - PW'(1));
					pos_q <= AW'(pos_c);
					end_q <= AW'(hi_c - PW'(1));
					val_q <= req.value;
				end
			end
			ST_SHIFT: begin
				pend_addr_q <= a_q + AW'(1);
				a_q         <= a_q - AW'(1);
			end
			ST_SCAN: begin
				a_q <= a_q + AW'(1);
				if (rv_q) begin
					acc_q <= (have_q && acc_q < rd_val) ? acc_q : rd_val;
				end
			end
			default: begin
				a_q <= a_q;
			end
		endcase
	end

	assign done   = done_q;
	assign result = result_q;
	assign count  = count_q;

endmodule

`default_nettype wire

// File: rtl/core/positional_insert_range_min_core.sv
// Top level of the positional insert / range minimum core: front queue
// plus back-end executor over one element RAM. Depends on pirm_pkg,
// pirm_front, pirm_back (and through it pirm_ram).
//
//  channel   | handshake       | payload
//  ----------+-----------------+-------------------------------------------------
//  request   | start / busy    | command, insert_position, insert_value,
//            |                 | query_left, query_right
//  result    | done (strobe)   | range_min, range_empty, insert_dropped
//
// Requests enter a two-entry queue; busy is high only while it is full.
// Insert at position p below the n stored entries: the back end shifts the
// entries from p upward, one RAM read/write per shifted entry; an append
// shifts none. Query over l..r with r clamped to n: one RAM read per entry.
// Dropped inserts and empty ranges skip the RAM; done is a registered strobe.
// Results show for one cycle on done; the receiver cannot stall them.
// Reset empties the sequence at once; the RAM itself is not cleared.
`default_nettype none

module positional_insert_range_min_core #(
	parameter int MAX_ELEMENTS = 1024
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic                              command,
	input  wire logic [pirm_pkg::POS_W-1:0]        insert_position,
	input  wire logic signed [pirm_pkg::VAL_W-1:0] insert_value,
	input  wire logic [pirm_pkg::POS_W-1:0]        query_left,
	input  wire logic [pirm_pkg::POS_W-1:0]        query_right,
	output logic                                   done,
	output logic signed [pirm_pkg::VAL_W-1:0]      range_min,
	output logic                                   range_empty,
	output logic                                   insert_dropped
);

	import pirm_pkg::*;

	localparam int CW = $clog2(MAX_ELEMENTS + 1);

	req_t          req;
	logic          req_valid;
	logic          req_pop;
	result_t       result;
	logic [CW-1:0] count;

	pirm_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.command         (command),
		.insert_position (insert_position),
		.insert_value    (insert_value),
		.query_left      (query_left),
		.query_right     (query_right),
		.busy            (busy),
		.req             (req),
		.req_valid       (req_valid),
		.req_pop         (req_pop)
	);

	pirm_back #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_valid (req_valid),
		.req_pop   (req_pop),
		.done      (done),
		.result    (result),
		.count     (count)
	);

	assign range_min      = result.range_min;
	assign range_empty    = result.range_empty;
	assign insert_dropped = result.insert_dropped;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CW'(MAX_ELEMENTS))
		else $error("element count above capacity");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(range_empty && insert_dropped))
		else $error("empty and dropped flags both set");

	a_empty_sentinel: assert property (@(posedge clk) disable iff (!arst_n)
		(done && range_empty) |-> (range_min == EMPTY_SENTINEL))
		else $error("empty range without sentinel");

	a_drop_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && insert_dropped) |-> (count == CW'(MAX_ELEMENTS)))
		else $error("insert dropped while store not full");

endmodule

`default_nettype wire
